// ===== design/lcdseq_pkg.sv =====
package lcdseq_pkg;

    // Configuration port
    localparam int CfgIndexWidth = 8;
    localparam int CfgDataWidth  = 16;
    localparam logic [CfgIndexWidth-1:0] CFG_END_COLUMN = 8'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_END_ROW    = 8'd1;
    localparam logic [15:0] END_COLUMN_RESET = 16'd319;
    localparam logic [15:0] END_ROW_RESET    = 16'd479;

    // Stream widths
    localparam int InDataWidth  = 80;
    localparam int InUserWidth  = 2;
    localparam int OutDataWidth = 16;
    localparam int OutUserWidth = 2;

    // Display controller commands
    localparam logic [15:0] CMD_COLUMN_SET = 16'h002A;
    localparam logic [15:0] CMD_ROW_SET    = 16'h002B;
    localparam logic [15:0] CMD_MEM_WRITE  = 16'h002C;

    // Positions in the twelve-word window/write sequence
    localparam logic [3:0] PH_COLUMN_SET = 4'd0;
    localparam logic [3:0] PH_XS_HI      = 4'd1;
    localparam logic [3:0] PH_XS_LO      = 4'd2;
    localparam logic [3:0] PH_XE_HI      = 4'd3;
    localparam logic [3:0] PH_XE_LO      = 4'd4;
    localparam logic [3:0] PH_ROW_SET    = 4'd5;
    localparam logic [3:0] PH_YS_HI      = 4'd6;
    localparam logic [3:0] PH_YS_LO      = 4'd7;
    localparam logic [3:0] PH_YE_HI      = 4'd8;
    localparam logic [3:0] PH_YE_LO      = 4'd9;
    localparam logic [3:0] PH_MEM_WRITE  = 4'd10;
    localparam logic [3:0] PH_COLOR      = 4'd11;

    // Request kinds; also used as the latched operation kind
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_POINT   = 2'd1,
        REQ_FILL    = 2'd2,
        REQ_OUTLINE = 2'd3
    } req_t;

    // Outline runs in drawing order
    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_BOTTOM = 2'd1,
        SIDE_LEFT   = 2'd2,
        SIDE_RIGHT  = 2'd3
    } side_t;

    // Sequencer state between beats
    typedef struct packed {
        logic        busy;
        req_t        kind;
        logic [3:0]  phase;
        side_t       side;
        logic [15:0] run_index;
        logic [31:0] pixels_left;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] color;
    } seq_state_t;

    // One result beat
    typedef struct packed {
        logic        is_command;
        logic [15:0] bus_word;
        logic        last;
        logic        dropped;
    } result_t;

endpackage

// ===== design/lcdseq_step.sv =====
module lcdseq_step (
    input  lcdseq_pkg::seq_state_t state_cur,
    input  lcdseq_pkg::req_t       req_type,
    input  logic [15:0]            x_start,
    input  logic [15:0]            y_start,
    input  logic [15:0]            width,
    input  logic [15:0]            height,
    input  logic [15:0]            pixel_color,
    input  logic [15:0]            point_end_column,
    input  logic [15:0]            point_end_row,
    output lcdseq_pkg::seq_state_t state_next,
    output logic                   emit,
    output lcdseq_pkg::result_t    result
);

    // Select the bus word of the window/write sequence: {is_command, word}
    function automatic logic [16:0] window_word(
        input logic [3:0]  phase,
        input logic [15:0] xs,
        input logic [15:0] xe,
        input logic [15:0] ys,
        input logic [15:0] ye,
        input logic [15:0] color
    );
        logic [16:0] ww;
        case (phase)
            lcdseq_pkg::PH_COLUMN_SET: ww = {1'b1, lcdseq_pkg::CMD_COLUMN_SET};
            lcdseq_pkg::PH_XS_HI:      ww = {1'b0, 8'h00, xs[15:8]};
            lcdseq_pkg::PH_XS_LO:      ww = {1'b0, 8'h00, xs[7:0]};
            lcdseq_pkg::PH_XE_HI:      ww = {1'b0, 8'h00, xe[15:8]};
            lcdseq_pkg::PH_XE_LO:      ww = {1'b0, 8'h00, xe[7:0]};
            lcdseq_pkg::PH_ROW_SET:    ww = {1'b1, lcdseq_pkg::CMD_ROW_SET};
            lcdseq_pkg::PH_YS_HI:      ww = {1'b0, 8'h00, ys[15:8]};
            lcdseq_pkg::PH_YS_LO:      ww = {1'b0, 8'h00, ys[7:0]};
            lcdseq_pkg::PH_YE_HI:      ww = {1'b0, 8'h00, ye[15:8]};
            lcdseq_pkg::PH_YE_LO:      ww = {1'b0, 8'h00, ye[7:0]};
            lcdseq_pkg::PH_MEM_WRITE:  ww = {1'b1, lcdseq_pkg::CMD_MEM_WRITE};
            default:                   ww = {1'b0, color};
        endcase
        return ww;
    endfunction

    lcdseq_pkg::seq_state_t cur;
    logic        start;
    logic        skip;
    logic        done;
    logic [16:0] ww;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] run_inc;
    logic [15:0] run_len;
    logic [31:0] pixels_dec;

    assign start = (req_type != lcdseq_pkg::REQ_TICK);

    // Latch a start, then emit the current word and advance the counters
    always_comb begin
        cur        = state_cur;
        skip       = 1'b0;
        done       = 1'b0;
        ww         = '0;
        px         = '0;
        py         = '0;
        run_inc    = '0;
        run_len    = '0;
        pixels_dec = '0;
        emit       = 1'b0;
        result     = '0;

        if (start && !state_cur.busy) begin
            cur.kind        = req_type;
            cur.x           = x_start;
            cur.y           = y_start;
            cur.w           = width;
            cur.h           = height;
            cur.color       = pixel_color;
            cur.phase       = lcdseq_pkg::PH_COLUMN_SET;
            cur.run_index   = '0;
            cur.side        = lcdseq_pkg::SIDE_TOP;
            cur.pixels_left = '0;
            if (req_type == lcdseq_pkg::REQ_FILL) begin
                cur.pixels_left = 32'(width) * 32'(height);
            end else if (req_type == lcdseq_pkg::REQ_OUTLINE) begin
                if (width != 16'd0) begin
                    cur.side = lcdseq_pkg::SIDE_TOP;
                end else if (height != 16'd0) begin
                    cur.side = lcdseq_pkg::SIDE_LEFT;
                end else begin
                    skip = 1'b1;
                end
            end
        end

        x_end = 16'(cur.x + cur.w - 16'd1);
        y_end = 16'(cur.y + cur.h - 16'd1);
        state_next = cur;

        if (start && state_cur.busy) begin
            // Drop the start, hold the stream where it is
            emit           = 1'b1;
            result.dropped = 1'b1;
        end else if ((start || state_cur.busy) && !skip) begin
            emit            = 1'b1;
            state_next.busy = 1'b1;
            case (cur.kind)
                lcdseq_pkg::REQ_FILL: begin
                    ww = window_word(cur.phase, cur.x, x_end, cur.y, y_end, cur.color);
                    if (cur.phase < lcdseq_pkg::PH_MEM_WRITE) begin
                        state_next.phase = cur.phase + 4'd1;
                    end else if (cur.phase == lcdseq_pkg::PH_MEM_WRITE) begin
                        if (cur.pixels_left == 32'd0) begin
                            done = 1'b1;
                        end else begin
                            state_next.phase = lcdseq_pkg::PH_COLOR;
                        end
                    end else begin
                        pixels_dec = (cur.pixels_left != 32'd0) ?
                                     cur.pixels_left - 32'd1 : 32'd0;
                        state_next.pixels_left = pixels_dec;
                        if (pixels_dec == 32'd0) begin
                            done = 1'b1;
                        end
                    end
                end
                lcdseq_pkg::REQ_OUTLINE: begin
                    case (cur.side)
                        lcdseq_pkg::SIDE_TOP: begin
                            px = 16'(cur.x + cur.run_index);
                            py = cur.y;
                        end
                        lcdseq_pkg::SIDE_BOTTOM: begin
                            px = 16'(cur.x + cur.run_index);
                            py = y_end;
                        end
                        lcdseq_pkg::SIDE_LEFT: begin
                            px = cur.x;
                            py = 16'(cur.y + cur.run_index);
                        end
                        default: begin
                            px = x_end;
                            py = 16'(cur.y + cur.run_index);
                        end
                    endcase
                    ww = window_word(cur.phase, px, point_end_column, py, point_end_row,
                                     cur.color);
                    run_len = (cur.side == lcdseq_pkg::SIDE_TOP ||
                               cur.side == lcdseq_pkg::SIDE_BOTTOM) ? cur.w : cur.h;
                    run_inc = 16'(cur.run_index + 16'd1);
                    if (cur.phase < lcdseq_pkg::PH_COLOR) begin
                        state_next.phase = cur.phase + 4'd1;
                    end else begin
                        state_next.phase = lcdseq_pkg::PH_COLUMN_SET;
                        if (run_inc >= run_len) begin
                            // Move to the next side that has a nonzero run
                            state_next.run_index = '0;
                            case (cur.side)
                                lcdseq_pkg::SIDE_TOP: state_next.side = lcdseq_pkg::SIDE_BOTTOM;
                                lcdseq_pkg::SIDE_BOTTOM: begin
                                    if (cur.h != 16'd0) begin
                                        state_next.side = lcdseq_pkg::SIDE_LEFT;
                                    end else begin
                                        done = 1'b1;
                                    end
                                end
                                lcdseq_pkg::SIDE_LEFT: state_next.side = lcdseq_pkg::SIDE_RIGHT;
                                default: done = 1'b1;
                            endcase
                        end else begin
                            state_next.run_index = run_inc;
                        end
                    end
                end
                default: begin
                    ww = window_word(cur.phase, cur.x, point_end_column, cur.y,
                                     point_end_row, cur.color);
                    if (cur.phase < lcdseq_pkg::PH_COLOR) begin
                        state_next.phase = cur.phase + 4'd1;
                    end else begin
                        done = 1'b1;
                    end
                end
            endcase
            result.is_command = ww[16];
            result.bus_word   = ww[15:0];
            if (done) begin
                result.last            = 1'b1;
                state_next.busy        = 1'b0;
                state_next.phase       = lcdseq_pkg::PH_COLUMN_SET;
                state_next.run_index   = '0;
                state_next.side        = lcdseq_pkg::SIDE_TOP;
                state_next.pixels_left = '0;
            end
        end
    end

endmodule

// ===== design/lcdseq_out_reg.sv =====
module lcdseq_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  lcdseq_pkg::result_t  result,
    output logic                 space,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [lcdseq_pkg::OutDataWidth-1:0] m_tdata,  // bus_word
    output logic [lcdseq_pkg::OutUserWidth-1:0] m_tuser,  // is_command, dropped
    output logic                 m_tlast
);

    logic                valid_reg;
    lcdseq_pkg::result_t data_reg;

    // Free when empty or when the held beat leaves this cycle
    assign space = !valid_reg || m_tready;

    // Hold the result beat until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.bus_word;
    assign m_tuser  = {data_reg.dropped, data_reg.is_command};
    assign m_tlast  = data_reg.last;

endmodule

// ===== design/lcd_draw_command_sequencer_top.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tuser = req_type; tdata = draw request fields
// m_        out        m_tvalid/m_tready    tdata = bus_word; tuser = flags; tlast = last
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each accepted beat is handled by combinational step logic: the sequencer state and the
// result register update on the accept edge, so one beat per cycle is sustained while the output is not stalled.
// A result beat appears in the cycle after its input beat is accepted; a tick while idle or an
// outline of zero size gives no result beat.
// aresetn is synchronous, active low; it clears the sequencer and the output valid.
// s_tready drops only while a result beat waits and m_tready is low.
module lcd_draw_command_sequencer_top (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // x_start[15:0], y_start[31:16], width[47:32], height[63:48], pixel_color[79:64]
    input  logic [lcdseq_pkg::InDataWidth-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [lcdseq_pkg::InUserWidth-1:0]   s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // bus_word[15:0]
    output logic [lcdseq_pkg::OutDataWidth-1:0]  m_tdata,
    // is_command[0], dropped[1]
    output logic [lcdseq_pkg::OutUserWidth-1:0]  m_tuser,
    output logic m_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [lcdseq_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [lcdseq_pkg::CfgDataWidth-1:0]  cfg_data
);

    lcdseq_pkg::seq_state_t state_reg;
    lcdseq_pkg::seq_state_t state_next;
    lcdseq_pkg::result_t    result;
    logic [15:0] end_column_reg;
    logic [15:0] end_row_reg;
    logic        emit;
    logic        space;
    logic        accept;

    assign s_tready  = space;
    assign accept    = s_tvalid && space;
    assign cfg_ready = 1'b1;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_column_reg <= lcdseq_pkg::END_COLUMN_RESET;
            end_row_reg    <= lcdseq_pkg::END_ROW_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == lcdseq_pkg::CFG_END_COLUMN) begin
                end_column_reg <= cfg_data;
            end else if (cfg_index == lcdseq_pkg::CFG_END_ROW) begin
                end_row_reg <= cfg_data;
            end
        end
    end

    lcdseq_step u_step (
        .state_cur        (state_reg),
        .req_type         (lcdseq_pkg::req_t'(s_tuser)),
        .x_start          (s_tdata[15:0]),
        .y_start          (s_tdata[31:16]),
        .width            (s_tdata[47:32]),
        .height           (s_tdata[63:48]),
        .pixel_color      (s_tdata[79:64]),
        .point_end_column (end_column_reg),
        .point_end_row    (end_row_reg),
        .state_next       (state_next),
        .emit             (emit),
        .result           (result)
    );

    // Advance the sequencer state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.busy        <= 1'b0;
            state_reg.kind        <= lcdseq_pkg::REQ_TICK;
            state_reg.phase       <= lcdseq_pkg::PH_COLUMN_SET;
            state_reg.side        <= lcdseq_pkg::SIDE_TOP;
            state_reg.run_index   <= '0;
            state_reg.pixels_left <= '0;
            state_reg.x           <= '0;
            state_reg.y           <= '0;
            state_reg.w           <= '0;
            state_reg.h           <= '0;
            state_reg.color       <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    lcdseq_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && emit),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
